### design/qsc_pkg.sv
// ----------------------------------------------------------------------------
// qsc_pkg: shared constants, types and helpers
// widths, pipeline latencies, register indexes, distance and arctangent table
// ----------------------------------------------------------------------------
package qsc_pkg;

  localparam int CW        = 12;              // coordinate width
  localparam int FRAC_BITS = 8;               // fraction bits of the side ratio
  localparam int CNT_W     = 4;
  localparam int RW        = 9;               // side ratio register width
  localparam int DW        = 7;               // degree register width
  localparam int OW        = 13;              // width and height fields
  localparam int D2W       = 2 * CW + 1;      // squared distance
  localparam int P1W       = D2W + RW;
  localparam int P2W       = D2W + 2 * RW;
  localparam int SQ_OUT_W  = (P2W + 1) / 2;
  localparam int SQ_IN_W   = 2 * SQ_OUT_W;
  localparam int CUT_W     = SQ_OUT_W - FRAC_BITS;
  localparam int NVEC      = 10;              // four corner pairs and the tilt pair

  localparam int ANG_FRAC  = 16;
  localparam int CORDIC_N  = 20;
  localparam int PRESCALE  = 20;
  localparam int XW        = CW + PRESCALE + 4;
  localparam int ZW        = 27;
  localparam int AW        = 22;
  localparam int ANG_W     = 8;

  localparam int FRONT_LAT  = 4;
  localparam int SQ_LAT     = SQ_OUT_W;
  localparam int CORDIC_LAT = CORDIC_N + 1;
  localparam int SIDE_DLY   = 2 + SQ_LAT + 1;
  localparam int FLAG_DLY   = 2 + SQ_LAT + 2;
  localparam int WH_DLY     = 4;
  localparam int ANG_DLY    = FRONT_LAT + FLAG_DLY - (FRONT_LAT + CORDIC_LAT + 2);
  localparam int PIPE_DEPTH = FRONT_LAT + FLAG_DLY + 1;

  localparam int IN_TW  = ((CNT_W + 8 * CW + 7) / 8) * 8;
  localparam int OUT_TW = ((1 + 2 * OW + 7) / 8) * 8;

  localparam logic [RW-1:0] SIDE_RATIO_RST = RW'(154);
  localparam logic [DW-1:0] ANGLE_TOL_RST  = DW'(20);
  localparam logic [DW-1:0] TILT_LIMIT_RST = DW'(30);

  typedef enum logic [1:0] {
    REG_SIDE_RATIO = 2'd0,
    REG_ANGLE_TOL  = 2'd1,
    REG_TILT_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                          count_ok;
    logic                          side_nz;
    logic                          tilt_nz;
    logic [3:0][D2W-1:0]           sides;   // ab, ac, db, dc
    logic [D2W-1:0]                w2;
    logic [D2W-1:0]                h2;
    logic [D2W-1:0]                m2;
    logic [NVEC-1:0][CW:0]         vx;
    logic [NVEC-1:0][CW:0]         vy;
  } geo_t;

  function automatic logic [D2W-1:0] dist2(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
                                           input logic [CW-1:0] bx, input logic [CW-1:0] by);
    logic signed [CW:0]     dx;
    logic signed [CW:0]     dy;
    logic signed [2*CW+1:0] qx;
    logic signed [2*CW+1:0] qy;
    dx = $signed({1'b0, bx}) - $signed({1'b0, ax});
    dy = $signed({1'b0, by}) - $signed({1'b0, ay});
    qx = dx * dx;
    qy = dy * dy;
    return {1'b0, qx[2*CW-1:0]} + {1'b0, qy[2*CW-1:0]};
  endfunction

  // atan(2^-i) in Q16 degrees
  function automatic logic [AW-1:0] atan_q16(input int unsigned i);
    logic [AW-1:0] v;
    case (i)
      0:  v = AW'(2949120);
      1:  v = AW'(1740967);
      2:  v = AW'(919879);
      3:  v = AW'(466945);
      4:  v = AW'(234379);
      5:  v = AW'(117304);
      6:  v = AW'(58666);
      7:  v = AW'(29335);
      8:  v = AW'(14668);
      9:  v = AW'(7334);
      10: v = AW'(3667);
      11: v = AW'(1833);
      12: v = AW'(917);
      13: v = AW'(458);
      14: v = AW'(229);
      15: v = AW'(115);
      16: v = AW'(57);
      17: v = AW'(29);
      18: v = AW'(14);
      19: v = AW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/qsc_front.sv
// ----------------------------------------------------------------------------
// qsc_front: corner sorting and side geometry
// four stages: bounding box, corner distances, corner pick, sides and vectors
// ----------------------------------------------------------------------------
module qsc_front (
  input  logic                          clk,
  input  logic                          en,
  input  logic [qsc_pkg::CNT_W-1:0]     point_count,
  input  logic [3:0][qsc_pkg::CW-1:0]   px,
  input  logic [3:0][qsc_pkg::CW-1:0]   py,
  output qsc_pkg::geo_t                 geo
);
  import qsc_pkg::*;

  // stage 1
  logic [3:0][CW-1:0] px1, py1;
  logic [CNT_W-1:0]   cnt1;
  logic [CW-1:0]      minx, maxx, miny, maxy;
  logic [CW-1:0]      minx_c, maxx_c, miny_c, maxy_c;
  // stage 2
  logic [3:0][CW-1:0] px2, py2;
  logic [CNT_W-1:0]   cnt2;
  logic [D2W-1:0]     d2 [4][4];
  // stage 3
  logic [3:0][CW-1:0] sx, sy;
  logic [CNT_W-1:0]   cnt3;
  logic [3:0][CW-1:0] sx_c, sy_c;
  logic [D2W-1:0]     best;
  // stage 4
  geo_t               geo_c;
  logic [CW-1:0]      fl, fr, fu, tx;
  logic [1:0]         pv, oth;

  always_comb begin
    minx_c = px[0]; maxx_c = px[0]; miny_c = py[0]; maxy_c = py[0];
    for (int i = 1; i < 4; i++) begin
      if (px[i] < minx_c) minx_c = px[i];
      if (px[i] > maxx_c) maxx_c = px[i];
      if (py[i] < miny_c) miny_c = py[i];
      if (py[i] > maxy_c) maxy_c = py[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= px; py1 <= py; cnt1 <= point_count;
      minx <= minx_c; maxx <= maxx_c; miny <= miny_c; maxy <= maxy_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px2 <= px1; py2 <= py1; cnt2 <= cnt1;
      for (int i = 0; i < 4; i++) begin
        d2[0][i] <= dist2(minx, miny, px1[i], py1[i]);
        d2[1][i] <= dist2(maxx, miny, px1[i], py1[i]);
        d2[2][i] <= dist2(minx, maxy, px1[i], py1[i]);
        d2[3][i] <= dist2(maxx, maxy, px1[i], py1[i]);
      end
    end
  end

  // first point with the strictly smallest distance wins
  always_comb begin
    sx_c = '0; sy_c = '0; best = '0;
    for (int j = 0; j < 4; j++) begin
      best = d2[j][0];
      sx_c[j] = px2[0];
      sy_c[j] = py2[0];
      for (int i = 1; i < 4; i++) begin
        if (d2[j][i] < best) begin
          best = d2[j][i];
          sx_c[j] = px2[i];
          sy_c[j] = py2[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx <= sx_c; sy <= sy_c; cnt3 <= cnt2;
    end
  end

  function automatic logic [CW:0] diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return {1'b0, a} - {1'b0, b};
  endfunction

  always_comb begin
    geo_c = '0;
    geo_c.sides[0] = dist2(sx[0], sy[0], sx[1], sy[1]);
    geo_c.sides[1] = dist2(sx[0], sy[0], sx[2], sy[2]);
    geo_c.sides[2] = dist2(sx[3], sy[3], sx[1], sy[1]);
    geo_c.sides[3] = dist2(sx[3], sy[3], sx[2], sy[2]);
    geo_c.w2 = (geo_c.sides[0] > geo_c.sides[3]) ? geo_c.sides[0] : geo_c.sides[3];
    geo_c.h2 = (geo_c.sides[1] > geo_c.sides[2]) ? geo_c.sides[1] : geo_c.sides[2];
    geo_c.m2 = (geo_c.w2 > geo_c.h2) ? geo_c.w2 : geo_c.h2;
    geo_c.count_ok = (cnt3 == CNT_W'(4));
    geo_c.side_nz  = (geo_c.sides[0] != '0) && (geo_c.sides[1] != '0) &&
                     (geo_c.sides[2] != '0) && (geo_c.sides[3] != '0);
    // corner vectors: corner to its two neighbours
    geo_c.vx[0] = diff(sx[2], sx[0]); geo_c.vy[0] = diff(sy[2], sy[0]);
    geo_c.vx[1] = diff(sx[1], sx[0]); geo_c.vy[1] = diff(sy[1], sy[0]);
    geo_c.vx[2] = diff(sx[0], sx[1]); geo_c.vy[2] = diff(sy[0], sy[1]);
    geo_c.vx[3] = diff(sx[3], sx[1]); geo_c.vy[3] = diff(sy[3], sy[1]);
    geo_c.vx[4] = diff(sx[0], sx[2]); geo_c.vy[4] = diff(sy[0], sy[2]);
    geo_c.vx[5] = diff(sx[3], sx[2]); geo_c.vy[5] = diff(sy[3], sy[2]);
    geo_c.vx[6] = diff(sx[2], sx[3]); geo_c.vy[6] = diff(sy[2], sy[3]);
    geo_c.vx[7] = diff(sx[1], sx[3]); geo_c.vy[7] = diff(sy[1], sy[3]);
    // tilt of the top edge against the horizontal through the box top
    fl = sx[0]; fr = sx[0]; fu = sy[0];
    for (int i = 1; i < 4; i++) begin
      if (sx[i] < fl) fl = sx[i];
      if (sx[i] > fr) fr = sx[i];
      if (sy[i] < fu) fu = sy[i];
    end
    if (sy[1] < sy[0]) begin
      pv = 2'd1; oth = 2'd0; tx = fl;
    end else begin
      pv = 2'd0; oth = 2'd1; tx = fr;
    end
    geo_c.vx[8] = diff(tx, sx[pv]);      geo_c.vy[8] = diff(fu, sy[pv]);
    geo_c.vx[9] = diff(sx[oth], sx[pv]); geo_c.vy[9] = diff(sy[oth], sy[pv]);
    geo_c.tilt_nz = ((geo_c.vx[8] != '0) || (geo_c.vy[8] != '0)) &&
                    ((geo_c.vx[9] != '0) || (geo_c.vy[9] != '0));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo <= geo_c;
    end
  end

endmodule

### design/qsc_isqrt.sv
// ----------------------------------------------------------------------------
// qsc_isqrt: pipelined integer square root
// restoring digit recurrence, one result bit per stage, floor result
// ----------------------------------------------------------------------------
module qsc_isqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [qsc_pkg::SQ_IN_W-1:0]    din,
  output logic [qsc_pkg::SQ_OUT_W-1:0]   root
);
  import qsc_pkg::*;

  localparam int N = SQ_OUT_W;

  logic [N+1:0]       rem_q  [N];
  logic [N-1:0]       root_q [N];
  logic [SQ_IN_W-1:0] rest_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N+1:0]       rem_p;
    logic [N-1:0]       root_p;
    logic [SQ_IN_W-1:0] rest_p;
    logic [N+1:0]       rem_sh;
    logic [N+1:0]       trial;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rest_p = din;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rest_p = rest_q[k-1];
    end

    assign rem_sh = {rem_p[N-1:0], rest_p[SQ_IN_W-1 -: 2]};
    assign trial  = {root_p, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rest_q[k] <= {rest_p[SQ_IN_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_p[N-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_p[N-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[N-1];

endmodule

### design/qsc_cordic.sv
// ----------------------------------------------------------------------------
// qsc_cordic: pipelined vector direction
// quarter-turn fold then cordic vectoring, direction in q16 degrees
// ----------------------------------------------------------------------------
module qsc_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic [qsc_pkg::CW:0]              vx,
  input  logic [qsc_pkg::CW:0]              vy,
  output logic signed [qsc_pkg::ZW-1:0]     dir
);
  import qsc_pkg::*;

  localparam logic signed [ZW-1:0] QUARTER = ZW'(90 << ANG_FRAC);

  logic signed [CW:0]   x_in, y_in;
  logic signed [CW:0]   xr, yr;
  logic [1:0]           turns;
  logic signed [XW-1:0] xs [CORDIC_N+1];
  logic signed [XW-1:0] ys [CORDIC_N+1];
  logic signed [ZW-1:0] zs [CORDIC_N+1];

  assign x_in = $signed(vx);
  assign y_in = $signed(vy);

  always_comb begin
    turns = 2'd0;
    xr    = '0;
    yr    = '0;
    if (x_in > 0 && y_in >= 0) begin
      xr = x_in;  yr = y_in;  turns = 2'd0;
    end else if (x_in <= 0 && y_in > 0) begin
      xr = y_in;  yr = -x_in; turns = 2'd1;
    end else if (x_in < 0 && y_in <= 0) begin
      xr = -x_in; yr = -y_in; turns = 2'd2;
    end else if (x_in >= 0 && y_in < 0) begin
      xr = -y_in; yr = x_in;  turns = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= XW'(xr) <<< PRESCALE;
      ys[0] <= XW'(yr) <<< PRESCALE;
      zs[0] <= QUARTER * $signed({1'b0, turns});
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(atan_q16(i)));
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] == '0) begin
          xs[i+1] <= xs[i];
          ys[i+1] <= ys[i];
          zs[i+1] <= zs[i];
        end else if (!ys[i][XW-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN;
        end
      end
    end
  end

  assign dir = zs[CORDIC_N];

endmodule

### design/quad_square_classifier.sv
// ----------------------------------------------------------------------------
// quad_square_classifier: four-corner square test
// sorts four contour points into corners and checks sides, angles and tilt
// ----------------------------------------------------------------------------
// One transaction in, one transaction out, one transaction per clock when the
// output side keeps up. From input handshake to output valid the pipeline has
// four stages of corner sorting, a pipelined square root of 22 stages
// for the side cut-off (with two multiply stages before and one after), and
// 21-stage cordic lanes for the ten direction vectors running alongside. All
// stages move together; when the output is stalled the whole pipeline holds,
// so s_axis_tready follows m_axis_tready or an empty output register. The
// three setting registers are written through cfg_wr_en/cfg_addr/cfg_wdata and
// must only change while no transaction is in flight.
// ----------------------------------------------------------------------------
module quad_square_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // point_count, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, zero pad
  input  logic [qsc_pkg::IN_TW-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // is_square, quad_width, quad_height, zero pad
  output logic [qsc_pkg::OUT_TW-1:0]    m_axis_tdata,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_addr,
  input  logic [qsc_pkg::RW-1:0]        cfg_wdata
);
  import qsc_pkg::*;

  localparam logic signed [ZW:0] HALF_TURN = (ZW+1)'(180 << ANG_FRAC);
  localparam logic signed [ZW:0] FULL_TURN = (ZW+1)'(360 << ANG_FRAC);

  // setting registers
  logic [RW-1:0] side_ratio;
  logic [DW-1:0] angle_tol;
  logic [DW-1:0] tilt_limit;

  // pipeline control
  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;

  // input unpacking
  logic [CNT_W-1:0]   point_count;
  logic [3:0][CW-1:0] px, py;

  geo_t geo;

  // side cut-off path
  logic [P1W-1:0]      prod1;
  logic [P2W-1:0]      prod2;
  logic [SQ_OUT_W-1:0] cut_root;
  logic [2*CUT_W-1:0]  cut2;
  logic [3:0][D2W-1:0] sides_d [SIDE_DLY];
  logic                side_ok;
  logic                side_ok_c;

  // width and height
  logic [SQ_OUT_W-1:0] w_root, h_root;
  logic [OW-1:0]       w_d [WH_DLY];
  logic [OW-1:0]       h_d [WH_DLY];

  // angle path
  logic signed [ZW-1:0] dir [NVEC];
  logic [ANG_W-1:0]     ang [5];
  logic                 ang_ok_d [ANG_DLY+1];
  logic                 tilt_ok_d [ANG_DLY+1];
  logic                 ang_ok_c;

  // early flags
  logic flag_d [FLAG_DLY];

  logic [OUT_TW-1:0] out_data;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      side_ratio <= SIDE_RATIO_RST;
      angle_tol  <= ANGLE_TOL_RST;
      tilt_limit <= TILT_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SIDE_RATIO: side_ratio <= cfg_wdata;
        REG_ANGLE_TOL:  angle_tol  <= cfg_wdata[DW-1:0];
        REG_TILT_LIMIT: tilt_limit <= cfg_wdata[DW-1:0];
        default: ;
      endcase
    end
  end

  // the whole pipeline advances unless a finished result is waiting and m_axis_tready is low
  assign en            = !vld[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[PIPE_DEPTH-1];
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  assign point_count = s_axis_tdata[CNT_W-1:0];
  for (genvar i = 0; i < 4; i++) begin : g_unpack
    assign px[i] = s_axis_tdata[CNT_W + 2*CW*i +: CW];
    assign py[i] = s_axis_tdata[CNT_W + 2*CW*i + CW +: CW];
  end

  qsc_front u_front (
    .clk         (clk),
    .en          (en),
    .point_count (point_count),
    .px          (px),
    .py          (py),
    .geo         (geo)
  );

  // cut-off = floor(sqrt(m2 * r * r)) >> frac, compared squared with each side
  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= P1W'(geo.m2) * P1W'(side_ratio);
      prod2 <= P2W'(prod1) * P2W'(side_ratio);
    end
  end

  qsc_isqrt u_cut_sqrt (
    .clk  (clk),
    .en   (en),
    .din  (SQ_IN_W'(prod2)),
    .root (cut_root)
  );

  // every side must reach the squared cut-off
  always_comb begin
    side_ok_c = 1'b1;
    for (int s = 0; s < 4; s++) begin
      if ((2*CUT_W)'(sides_d[SIDE_DLY-1][s]) < cut2) side_ok_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cut2 <= (2*CUT_W)'(cut_root[SQ_OUT_W-1:FRAC_BITS]) *
              (2*CUT_W)'(cut_root[SQ_OUT_W-1:FRAC_BITS]);
      sides_d[0] <= geo.sides;
      for (int i = 1; i < SIDE_DLY; i++) sides_d[i] <= sides_d[i-1];
      side_ok <= side_ok_c;
    end
  end

  // width and height roots
  qsc_isqrt u_w_sqrt (
    .clk  (clk),
    .en   (en),
    .din  (SQ_IN_W'(geo.w2)),
    .root (w_root)
  );

  qsc_isqrt u_h_sqrt (
    .clk  (clk),
    .en   (en),
    .din  (SQ_IN_W'(geo.h2)),
    .root (h_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      w_d[0] <= w_root[OW-1:0];
      h_d[0] <= h_root[OW-1:0];
      for (int i = 1; i < WH_DLY; i++) begin
        w_d[i] <= w_d[i-1];
        h_d[i] <= h_d[i-1];
      end
    end
  end

  // directions of the eight corner vectors and the two tilt vectors
  for (genvar v = 0; v < NVEC; v++) begin : g_lane
    qsc_cordic u_cordic (
      .clk (clk),
      .en  (en),
      .vx  (geo.vx[v]),
      .vy  (geo.vy[v]),
      .dir (dir[v])
    );
  end

  // folded whole-degree angle between two directions, 0 to 180
  function automatic logic [ANG_W-1:0] fold_deg(input logic signed [ZW-1:0] a,
                                                input logic signed [ZW-1:0] b);
    logic signed [ZW:0] d;
    d = (ZW+1)'(a) - (ZW+1)'(b);
    if (d < 0) d = -d;
    if (d > HALF_TURN) d = FULL_TURN - d;
    if (d < 0) d = '0;
    return d[ANG_FRAC +: ANG_W];
  endfunction

  always_comb begin
    ang_ok_c = 1'b1;
    for (int c = 0; c < 4; c++) begin
      // lower bound as a + tol >= 90, upper as a <= 90 + tol
      if (({1'b0, ang[c]} + 9'(angle_tol)) < 9'd90) ang_ok_c = 1'b0;
      if ({1'b0, ang[c]} > (9'd90 + 9'(angle_tol))) ang_ok_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) ang[c] <= fold_deg(dir[2*c], dir[2*c+1]);
      ang[4] <= fold_deg(dir[8], dir[9]);
      ang_ok_d[0]  <= ang_ok_c;
      tilt_ok_d[0] <= (ang[4] <= ANG_W'(tilt_limit));
      for (int i = 1; i <= ANG_DLY; i++) begin
        ang_ok_d[i]  <= ang_ok_d[i-1];
        tilt_ok_d[i] <= tilt_ok_d[i-1];
      end
    end
  end

  // count, zero-side and zero tilt vector checks travel alongside
  always_ff @(posedge clk) begin
    if (en) begin
      flag_d[0] <= geo.count_ok && geo.side_nz && geo.tilt_nz;
      for (int i = 1; i < FLAG_DLY; i++) flag_d[i] <= flag_d[i-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= {(OUT_TW-1-2*OW)'(0), h_d[WH_DLY-1], w_d[WH_DLY-1],
                   flag_d[FLAG_DLY-1] && side_ok && ang_ok_d[ANG_DLY] &&
                   tilt_ok_d[ANG_DLY]};
    end
  end

  // a square always has nonzero sides
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> (m_axis_tdata[OW:1] != '0) &&
                                         (m_axis_tdata[2*OW:OW+1] != '0))
    else $error("square reported with zero width or height");

  // a stall freezes every stage's valid bit
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  // nothing leaves the pipeline right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid directly after reset");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quad_square_classifier
// random and directed contours through the stream ports, compared against a
// bit-accurate corner sort, square root and cordic angle predictor
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qsc_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE      = 60;     // comfortably above the pipeline latency
  localparam logic [1:0]  REG_SPARE   = 2'd3;   // index with no register behind it
  localparam int          SQUARE_CNT  = 4;

  typedef struct {
    bit       square;
    bit [12:0] width;
    bit [12:0] height;
  } verdict_t;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_TW-1:0]  s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_TW-1:0] m_axis_tdata;
  logic              cfg_wr_en;
  logic [1:0]        cfg_addr;
  logic [RW-1:0]     cfg_wdata;

  quad_square_classifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  // contours waiting to be sent, verdicts waiting to come back
  logic [IN_TW-1:0] contour_q[$];
  verdict_t         verdict_q[$];

  // shadow copy of the setting registers
  int unsigned ratio_q8 = 154;
  int unsigned tol_deg  = 20;
  int unsigned tilt_deg = 30;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off      = 0;
  int errors        = 0;
  int cycles        = 0;

  // --------------------------------------------------------------------------
  // arithmetic helpers mirroring the fixed-point behaviour
  // --------------------------------------------------------------------------
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint sq_dist(input longint ax, input longint ay,
                                     input longint bx, input longint by);
    return (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
  endfunction

  // direction of a nonzero vector in Q16 degrees
  function automatic longint heading_q16(input longint x, input longint y);
    longint atan_tab[20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                             29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                             29, 14, 7};
    longint base, z, t, nx, ny;
    base = 0;
    z = 0;
    for (int k = 0; k < 4 && !(x > 0 && y >= 0); k++) begin
      t = x;
      x = y;
      y = -t;
      base += longint'(90) << 16;
    end
    if (!(x > 0 && y >= 0)) return 0;
    x = x <<< 20;
    y = y <<< 20;
    for (int i = 0; i < 20; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += atan_tab[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= atan_tab[i];
      end
      x = nx;
      y = ny;
    end
    return base + z;
  endfunction

  // whole-degree angle between two vectors, folded into 0..180
  function automatic longint angle_between(input longint ux, input longint uy,
                                           input longint vx, input longint vy);
    longint d;
    d = heading_q16(ux, uy) - heading_q16(vx, vy);
    if (d < 0) d = -d;
    if (d > (longint'(180) << 16)) d = (longint'(360) << 16) - d;
    if (d < 0) d = 0;
    return d >> 16;
  endfunction

  // expected verdict for one contour under the current settings
  function automatic verdict_t classify(input logic [IN_TW-1:0] d);
    int     nb_u[4] = '{2, 0, 0, 2};
    int     nb_v[4] = '{1, 3, 3, 1};
    longint px[4], py[4], sx[4], sy[4], bx[4], by[4], best[4];
    longint minx, miny, maxx, maxy, dd, ab, ac, db, dc, w2, h2, m2, cut, cut2;
    longint lo, hi, fl, fr, fu, tx, ux, uy, vx, vy;
    int     pv, oth;
    bit     ok;
    verdict_t v;
    for (int i = 0; i < 4; i++) begin
      px[i] = longint'(d[4 + 24 * i +: 12]);
      py[i] = longint'(d[16 + 24 * i +: 12]);
    end
    minx = px[0]; maxx = px[0]; miny = py[0]; maxy = py[0];
    for (int i = 1; i < 4; i++) begin
      if (px[i] < minx) minx = px[i];
      if (px[i] > maxx) maxx = px[i];
      if (py[i] < miny) miny = py[i];
      if (py[i] > maxy) maxy = py[i];
    end
    bx = '{minx, maxx, minx, maxx};
    by = '{miny, miny, maxy, maxy};
    // nearest point to each box corner, first one wins a tie
    for (int j = 0; j < 4; j++) begin
      best[j] = sq_dist(bx[j], by[j], px[0], py[0]);
      sx[j] = px[0];
      sy[j] = py[0];
      for (int i = 1; i < 4; i++) begin
        dd = sq_dist(bx[j], by[j], px[i], py[i]);
        if (dd < best[j]) begin
          best[j] = dd;
          sx[j] = px[i];
          sy[j] = py[i];
        end
      end
    end
    ab = sq_dist(sx[0], sy[0], sx[1], sy[1]);
    ac = sq_dist(sx[0], sy[0], sx[2], sy[2]);
    db = sq_dist(sx[3], sy[3], sx[1], sy[1]);
    dc = sq_dist(sx[3], sy[3], sx[2], sy[2]);
    w2 = ab > dc ? ab : dc;
    h2 = ac > db ? ac : db;
    m2 = w2 > h2 ? w2 : h2;
    ok = d[3:0] == SQUARE_CNT && ab != 0 && ac != 0 && db != 0 && dc != 0;
    if (ok) begin
      cut  = int_sqrt(m2 * ratio_q8 * ratio_q8) >> 8;
      cut2 = cut * cut;
      if (ab < cut2 || ac < cut2 || db < cut2 || dc < cut2) ok = 0;
    end
    if (ok) begin
      lo = 90 - longint'(tol_deg);
      hi = 90 + longint'(tol_deg);
      for (int c = 0; c < 4 && ok; c++) begin
        dd = angle_between(sx[nb_u[c]] - sx[c], sy[nb_u[c]] - sy[c],
                           sx[nb_v[c]] - sx[c], sy[nb_v[c]] - sy[c]);
        if (dd < lo || dd > hi) ok = 0;
      end
    end
    if (ok) begin
      // tilt of the top edge against the horizontal through the box top
      fl = sx[0]; fr = sx[0]; fu = sy[0];
      for (int i = 1; i < 4; i++) begin
        if (sx[i] < fl) fl = sx[i];
        if (sx[i] > fr) fr = sx[i];
        if (sy[i] < fu) fu = sy[i];
      end
      if (sy[1] < sy[0]) begin
        pv = 1; oth = 0; tx = fl;
      end else begin
        pv = 0; oth = 1; tx = fr;
      end
      ux = tx - sx[pv];
      uy = fu - sy[pv];
      vx = sx[oth] - sx[pv];
      vy = sy[oth] - sy[pv];
      if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0)) ok = 0;
      else if (angle_between(ux, uy, vx, vy) > longint'(tilt_deg)) ok = 0;
    end
    v.square = ok;
    v.width  = 13'(int_sqrt(w2));
    v.height = 13'(int_sqrt(h2));
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus builders
  // --------------------------------------------------------------------------
  function automatic logic [IN_TW-1:0] pack_contour(input int cnt, input int xs[4],
                                                    input int ys[4]);
    logic [IN_TW-1:0] d;
    d = '0;
    d[3:0] = 4'(cnt);
    for (int i = 0; i < 4; i++) begin
      d[4 + 24 * i +: 12]  = 12'(xs[i]);
      d[16 + 24 * i +: 12] = 12'(ys[i]);
    end
    return d;
  endfunction

  function automatic int clip(input int v);
    return v < 0 ? 0 : (v > 4095 ? 4095 : v);
  endfunction

  // rotated, jittered square in shuffled order, with the odd wrong count
  function automatic logic [IN_TW-1:0] near_square();
    int a, b, cx, cy, jit, r;
    int xs[4], ys[4], ox[4], oy[4];
    a   = $urandom_range(1, 600);
    b   = $urandom_range(0, 2 * (a / 2)) - a / 2;
    cx  = $urandom_range(700, 3400);
    cy  = $urandom_range(700, 3400);
    jit = $urandom_range(0, 3) == 0 ? $urandom_range(0, a / 3 + 1) : $urandom_range(0, 2);
    ox = '{a, -b, -a, b};
    oy = '{b, a, -b, -a};
    for (int i = 0; i < 4; i++) begin
      xs[i] = clip(cx + ox[i] + $urandom_range(0, 2 * jit) - jit);
      ys[i] = clip(cy + oy[i] + $urandom_range(0, 2 * jit) - jit);
    end
    for (int i = 3; i > 0; i--) begin
      r = $urandom_range(0, i);
      a = xs[i]; xs[i] = xs[r]; xs[r] = a;
      a = ys[i]; ys[i] = ys[r]; ys[r] = a;
    end
    return pack_contour($urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : SQUARE_CNT,
                        xs, ys);
  endfunction

  function automatic logic [IN_TW-1:0] noise_contour();
    int xs[4], ys[4];
    for (int i = 0; i < 4; i++) begin
      xs[i] = $urandom_range(0, 4095);
      ys[i] = $urandom_range(0, 4095);
    end
    // sometimes copy point 0's x to a random point and point 0's y to point 1
    if ($urandom_range(0, 3) == 0) begin
      xs[$urandom_range(0, 3)] = xs[0];
      ys[1] = ys[0];
    end
    return pack_contour($urandom_range(0, 1) ? SQUARE_CNT : $urandom_range(0, 15), xs, ys);
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++)
      contour_q.push_back($urandom_range(0, 99) < 75 ? near_square() : noise_contour());
  endtask

  task automatic queue_directed();
    contour_q.push_back(pack_contour(4, '{0, 4095, 0, 4095}, '{0, 0, 4095, 4095}));
    contour_q.push_back(pack_contour(4, '{4095, 0, 4095, 0}, '{4095, 4095, 0, 0}));
    contour_q.push_back(pack_contour(0, '{0, 4095, 0, 4095}, '{0, 0, 4095, 4095}));
    contour_q.push_back(pack_contour(15, '{10, 20, 10, 20}, '{10, 10, 20, 20}));
    contour_q.push_back(pack_contour(3, '{10, 20, 10, 20}, '{10, 10, 20, 20}));
    contour_q.push_back(pack_contour(5, '{10, 20, 10, 20}, '{10, 10, 20, 20}));
    contour_q.push_back(pack_contour(4, '{0, 0, 0, 0}, '{0, 0, 0, 0}));
    contour_q.push_back(pack_contour(4, '{4095, 4095, 4095, 4095}, '{4095, 4095, 4095, 4095}));
    // one-pixel square, zero-length side via repeated corner
    contour_q.push_back(pack_contour(4, '{100, 101, 100, 101}, '{100, 100, 101, 101}));
    contour_q.push_back(pack_contour(4, '{100, 200, 100, 100}, '{100, 100, 200, 100}));
    // thin rectangle fails the side test, diamond is tilted by 45 degrees
    contour_q.push_back(pack_contour(4, '{100, 900, 100, 900}, '{100, 100, 150, 150}));
    contour_q.push_back(pack_contour(4, '{500, 900, 500, 100}, '{100, 500, 900, 500}));
    // a mildly rotated square, two sheared ones and a square in shuffled order
    contour_q.push_back(pack_contour(4, '{1000, 1400, 900, 1300}, '{1000, 1100, 1400, 1500}));
    contour_q.push_back(pack_contour(4, '{2000, 2300, 1800, 2100}, '{2000, 2050, 2300, 2350}));
    contour_q.push_back(pack_contour(4, '{300, 700, 500, 900}, '{300, 300, 700, 700}));
    contour_q.push_back(pack_contour(4, '{2730, 1365, 2730, 1365}, '{1365, 2730, 2730, 1365}));
  endtask

  // --------------------------------------------------------------------------
  // clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // input driver: prediction taken at the accepting edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) verdict_q.push_back(classify(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (contour_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tdata  <= contour_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output monitor and back-pressure
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected transaction, actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (m_axis_tdata[0] !== exp_v.square) begin
            $display("%0t: is_square expected %0d actual %0d", $time, exp_v.square,
                     m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[13:1] !== exp_v.width) begin
            $display("%0t: quad_width expected %0d actual %0d", $time, exp_v.width,
                     m_axis_tdata[13:1]);
            errors++;
          end
          if (m_axis_tdata[26:14] !== exp_v.height) begin
            $display("%0t: quad_height expected %0d actual %0d", $time, exp_v.height,
                     m_axis_tdata[26:14]);
            errors++;
          end
        end
      end
      // a long hold-off lets the pipeline fill and push back on the input
      if (hold_off > 0) begin
        hold_off      <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequencing
  // --------------------------------------------------------------------------
  task automatic write_setting(input logic [1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= RW'(val);
    case (idx)
      REG_SIDE_RATIO: ratio_q8 = val & 9'h1ff;
      REG_ANGLE_TOL:  tol_deg  = val & 7'h7f;
      REG_TILT_LIMIT: tilt_deg = val & 7'h7f;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_settings(input int unsigned r, input int unsigned a,
                                input int unsigned t);
    write_setting(REG_SIDE_RATIO, r);
    write_setting(REG_ANGLE_TOL, a);
    write_setting(REG_TILT_LIMIT, t);
  endtask

  // sender pause: wait for every verdict, then let the pipe settle
  task automatic drain();
    wait (contour_q.size() == 0 && !s_axis_tvalid && verdict_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings, directed contours
    queue_directed();
    drain();

    // sender and receiver both idle, long receiver stall in the middle
    send_idle_pct = 35;
    recv_idle_pct = 52;
    queue_random(40);
    hold_off = 300;
    queue_random(40);
    drain();

    apply_settings(0, 0, 0);
    write_setting(REG_SPARE, 9'h1ff);
    send_idle_pct = 52;
    recv_idle_pct = 35;
    queue_directed();
    queue_random(70);
    drain();

    apply_settings(256, 89, 90);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(70);
    drain();

    // out-of-range settings: wide tolerance and ratio above one
    apply_settings(511, 127, 127);
    queue_directed();
    queue_random(60);
    drain();

    apply_settings($urandom_range(120, 256), $urandom_range(5, 40), $urandom_range(5, 60));
    queue_random(60);
    drain();

    apply_settings(154, 20, 30);
    queue_random(60);
    drain();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
